>>> rtl/multicart_rom_ram_bank_mapper_macros.svh
// ----------------------------------------------------------------------------
// multicart bank mapper assertion macros
// shared concurrent assertion forms for the mapper rtl
// ----------------------------------------------------------------------------
`ifndef MULTICART_ROM_RAM_BANK_MAPPER_MACROS_SVH
`define MULTICART_ROM_RAM_BANK_MAPPER_MACROS_SVH

// same-cycle implication
`define MBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mapper assertion failed");

// next-cycle implication
`define MBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mapper assertion failed");

`endif

>>> rtl/mbcmap_pkg.sv
// ----------------------------------------------------------------------------
// mbcmap_pkg
// types and constants shared by the multicart bank mapper
// ----------------------------------------------------------------------------
package mbcmap_pkg;

  // external ram size in bytes
  localparam int RamBytes = 8192;

  // field widths
  localparam int BankMaskW = 6;
  localparam int RomAddrW  = 20;
  localparam int BankOffW  = 14;

  // request type codes
  localparam logic ReqWrite = 1'b1;

  // base of the external ram window
  localparam logic [15:0] RamBase = 16'hA000;

  // register values
  localparam logic [7:0] OpenBus    = 8'hFF;
  localparam logic [3:0] EnableCode = 4'hA;

  // configuration register indexes
  typedef enum logic {
    CFG_ROM_BANK_MASK = 1'b0,
    CFG_RAM_PRESENT   = 1'b1
  } cfg_e;

  // result source codes
  typedef enum logic [1:0] {
    SRC_ROM   = 2'd0,
    SRC_DATA  = 2'd1,
    SRC_WRITE = 2'd2
  } src_e;

  // 8 KiB address windows (address bits 15:13)
  typedef enum logic [2:0] {
    WIN_ENABLE    = 3'd0,
    WIN_BANK_LOW  = 3'd1,
    WIN_BANK_HIGH = 3'd2,
    WIN_MODE      = 3'd3,
    WIN_VIDEO     = 3'd4,
    WIN_EXT_RAM   = 3'd5,
    WIN_WORK_RAM  = 3'd6,
    WIN_HIGH      = 3'd7
  } win_e;

  // ram access command from the mapper to the ram
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] wdata;
  } ram_cmd_t;

endpackage

>>> rtl/mbcmap_req_if.sv
// ----------------------------------------------------------------------------
// mbcmap_req_if
// bus access request channel: valid/ready with the access fields
// ----------------------------------------------------------------------------
interface mbcmap_req_if;

  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] bus_address;
  logic [7:0]  write_byte;

  modport source (output valid, output req_type, output bus_address, output write_byte,
                  input ready);
  modport sink (input valid, input req_type, input bus_address, input write_byte,
                output ready);

endinterface

>>> rtl/mbcmap_rsp_if.sv
// ----------------------------------------------------------------------------
// mbcmap_rsp_if
// access result channel: valid/ready with the result fields
// ----------------------------------------------------------------------------
interface mbcmap_rsp_if;

  logic        valid;
  logic        ready;
  logic [1:0]  read_source;
  logic [19:0] rom_address;
  logic [7:0]  read_byte;
  logic        ram_disabled_event;

  modport source (output valid, output read_source, output rom_address, output read_byte,
                  output ram_disabled_event, input ready);
  modport sink (input valid, input read_source, input rom_address, input read_byte,
                input ram_disabled_event, output ready);

endinterface

>>> rtl/mbcmap_ram.sv
// ----------------------------------------------------------------------------
// mbcmap_ram
// external ram with a registered read and a
// clearing sweep to 0xFF after reset
// ----------------------------------------------------------------------------
module mbcmap_ram #(
  parameter int RAM_BYTES = mbcmap_pkg::RamBytes,
  localparam int Aw = $clog2(RAM_BYTES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mbcmap_pkg::ram_cmd_t cmd_i,
  input  logic [Aw-1:0]        addr_i,
  output logic [7:0]           rd_data_o,
  output logic                 busy_o
);
  import mbcmap_pkg::*;

  logic [7:0]    mem [RAM_BYTES];
  logic [7:0]    rd_q;
  logic [Aw-1:0] clr_addr_q, clr_addr_d;
  logic          busy_q, busy_d;
  logic          wr_en;
  logic [Aw-1:0] wr_addr;
  logic [7:0]    wr_data;

  // clearing sweep, one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + Aw'(1);
      if (clr_addr_q == Aw'(RAM_BYTES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
    end
  end

  // write port shared between sweep and accesses
  assign wr_en   = busy_q || cmd_i.wr_en;
  assign wr_addr = busy_q ? clr_addr_q : addr_i;
  assign wr_data = busy_q ? OpenBus : cmd_i.wdata;

  // memory array, read data held until the next read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

>>> rtl/multicart_rom_ram_bank_mapper.sv
// ----------------------------------------------------------------------------
// multicart_rom_ram_bank_mapper
// multicart rom/ram bank controller: maps cartridge bus accesses to rom
// offsets and external ram, and keeps the banking registers
// ----------------------------------------------------------------------------
// One bus request is taken per clock while the ram is not sweeping and the
// first stage is free or moving on; its result is registered in the first
// stage, alongside the registered ram read, and then in the output register.
// The pipeline holds two results under backpressure. Control writes take
// effect for the very next request. Each request issues at most one read or
// write to the external ram. After reset the ram is swept to 0xFF, one byte
// a cycle, across all RAM_BYTES (8192) entries; no request is accepted during
// that sweep, while configuration writes are taken at any time.

`include "multicart_rom_ram_bank_mapper_macros.svh"

module multicart_rom_ram_bank_mapper #(
  parameter int RAM_BYTES = mbcmap_pkg::RamBytes
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  mbcmap_pkg::cfg_e                      cfg_index_i,
  input  logic [mbcmap_pkg::BankMaskW-1:0]      cfg_data_i,
  mbcmap_req_if.sink                            req_i,
  mbcmap_rsp_if.source                          rsp_o
);
  import mbcmap_pkg::*;

  localparam int Aw = $clog2(RAM_BYTES);

  // configuration and banking registers
  logic [BankMaskW-1:0] rom_mask_q;
  logic                 ram_present_q;
  logic [4:0]           bank_low_q, bank_low_d;
  logic [1:0]           bank_high_q, bank_high_d;
  logic                 mode_q, mode_d;
  logic                 ram_enable_q, ram_enable_d;

  // pipeline
  logic                 s1_valid_q;
  logic [1:0]           s1_src_q;
  logic [RomAddrW-1:0]  s1_rom_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_use_ram_q;
  logic                 s1_ev_q;
  logic                 out_valid_q;
  logic [1:0]           out_src_q;
  logic [RomAddrW-1:0]  out_rom_q;
  logic [7:0]           out_byte_q;
  logic                 out_ev_q;

  // request decode
  logic                 accept;
  logic                 s1_move;
  logic                 is_write;
  win_e                 window;
  logic [BankMaskW-1:0] bank0, bank1;
  logic [15:0]          ram_off;
  logic                 ram_hit;
  src_e                 src_c;
  logic [RomAddrW-1:0]  rom_c;
  logic [7:0]           byte_c;
  logic                 use_ram_c;
  logic                 ev_c;

  ram_cmd_t             ram_cmd;
  logic [7:0]           ram_rd;
  logic                 ram_busy;

  // handshake
  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !ram_busy && (!s1_valid_q || s1_move);
  assign accept      = req_i.valid && req_i.ready;

  assign is_write = (req_i.req_type == ReqWrite);
  assign window   = win_e'(req_i.bus_address[15:13]);
  assign ram_off  = req_i.bus_address - RamBase;
  assign ram_hit  = (window == WIN_EXT_RAM) && ram_enable_q && ram_present_q;

  // bank numbers from live registers and mask
  assign bank0 = {bank_high_q, 4'b0000} & rom_mask_q;
  assign bank1 = ({bank_high_q, bank_low_q[3:0]}
                 | {{(BankMaskW-1){1'b0}}, (bank_low_q == 5'd0)}) & rom_mask_q;

  // result and register updates for the offered request
  always_comb begin
    src_c        = SRC_DATA;
    rom_c        = '0;
    byte_c       = '0;
    use_ram_c    = 1'b0;
    ev_c         = 1'b0;
    bank_low_d   = bank_low_q;
    bank_high_d  = bank_high_q;
    mode_d       = mode_q;
    ram_enable_d = ram_enable_q;
    if (is_write) begin
      src_c = SRC_WRITE;
      case (window)
        WIN_ENABLE: begin
          if (ram_present_q) begin
            ram_enable_d = (req_i.write_byte[3:0] == EnableCode);
            ev_c         = ram_enable_q && !ram_enable_d;
          end
        end
        WIN_BANK_LOW:  bank_low_d  = req_i.write_byte[4:0];
        WIN_BANK_HIGH: bank_high_d = req_i.write_byte[1:0];
        WIN_MODE:      mode_d      = req_i.write_byte[0];
        default: ;
      endcase
    end else begin
      case (window)
        WIN_ENABLE, WIN_BANK_LOW: begin
          src_c = SRC_ROM;
          rom_c = mode_q ? {bank0, req_i.bus_address[BankOffW-1:0]}
                         : {{(RomAddrW-BankOffW){1'b0}}, req_i.bus_address[BankOffW-1:0]};
        end
        WIN_BANK_HIGH, WIN_MODE: begin
          src_c = SRC_ROM;
          rom_c = {bank1, req_i.bus_address[BankOffW-1:0]};
        end
        default: begin
          if (ram_hit) begin
            use_ram_c = 1'b1;
          end else begin
            byte_c = OpenBus;
          end
        end
      endcase
    end
  end

  // ram command
  assign ram_cmd.rd_en = accept && !is_write && ram_hit;
  assign ram_cmd.wr_en = accept && is_write && ram_hit;
  assign ram_cmd.wdata = req_i.write_byte;

  mbcmap_ram #(
    .RAM_BYTES(RAM_BYTES)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ram_cmd),
    .addr_i    (ram_off[Aw-1:0]),
    .rd_data_o (ram_rd),
    .busy_o    (ram_busy)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_mask_q    <= '1;
      ram_present_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROM_BANK_MASK: rom_mask_q    <= cfg_data_i;
        CFG_RAM_PRESENT:   ram_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // banking registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_low_q   <= 5'd1;
      bank_high_q  <= '0;
      mode_q       <= 1'b0;
      ram_enable_q <= 1'b0;
    end else if (accept) begin
      bank_low_q   <= bank_low_d;
      bank_high_q  <= bank_high_d;
      mode_q       <= mode_d;
      ram_enable_q <= ram_enable_d;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_src_q     <= src_c;
      s1_rom_q     <= rom_c;
      s1_byte_q    <= byte_c;
      s1_use_ram_q <= use_ram_c;
      s1_ev_q      <= ev_c;
    end
    if (s1_move) begin
      out_src_q  <= s1_src_q;
      out_rom_q  <= s1_rom_q;
      out_byte_q <= s1_use_ram_q ? ram_rd : s1_byte_q;
      out_ev_q   <= s1_ev_q;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.read_source        = out_src_q;
  assign rsp_o.rom_address        = out_rom_q;
  assign rsp_o.read_byte          = out_byte_q;
  assign rsp_o.ram_disabled_event = out_ev_q;

  // checks
  `MBC_ASSERT_IMPL(a_no_accept_in_clear, clk_i, rst_ni, ram_busy, !req_i.ready)
  `MBC_ASSERT_IMPL(a_full_stall_blocks, clk_i, rst_ni, s1_valid_q && out_valid_q && !rsp_o.ready, !req_i.ready)
  `MBC_ASSERT_IMPL(a_event_on_write, clk_i, rst_ni, out_valid_q && out_ev_q, out_src_q == SRC_WRITE)
  `MBC_ASSERT_NEXT(a_enable_cleared, clk_i, rst_ni, accept && is_write && ram_present_q && window == WIN_ENABLE && req_i.write_byte[3:0] != EnableCode, !ram_enable_q)

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multicart bank mapper: a short table of directed
// bus accesses, then random access mixes under several mask and ram settings
// with random idling on both channels, checked against a bank-state predictor
// ----------------------------------------------------------------------------
module tb_top;
  import mbcmap_pkg::*;

  localparam logic ReqRead    = ~ReqWrite;
  localparam int   StallLimit = 30000;
  localparam int   PhaseItems = 250;

  // one result of a bus access
  typedef struct packed {
    src_e        src;
    logic [19:0] rom_addr;
    logic [7:0]  rbyte;
    logic        ev;
  } access_rsp_t;

  // one bus access, with a typed-in result where pinned is set
  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        pinned;
    access_rsp_t want;
  } stim_row_t;

  localparam access_rsp_t NoRsp = '{SRC_ROM, 20'h00000, 8'h00, 1'b0};

  // directed accesses, starting from the reset state
  localparam stim_row_t DirectedRows [26] = '{
    '{ReqRead,  16'h0000, 8'h00, 1'b1, '{SRC_ROM,   20'h00000, 8'h00, 1'b0}},
    '{ReqRead,  16'h3FFF, 8'hFF, 1'b1, '{SRC_ROM,   20'h03FFF, 8'h00, 1'b0}},
    '{ReqRead,  16'h4000, 8'h00, 1'b1, '{SRC_ROM,   20'h04000, 8'h00, 1'b0}},
    '{ReqRead,  16'h7FFF, 8'h00, 1'b1, '{SRC_ROM,   20'h07FFF, 8'h00, 1'b0}},
    '{ReqRead,  16'hA000, 8'h00, 1'b1, '{SRC_DATA,  20'h00000, 8'hFF, 1'b0}},
    '{ReqRead,  16'h8000, 8'h00, 1'b1, '{SRC_DATA,  20'h00000, 8'hFF, 1'b0}},
    '{ReqRead,  16'hFFFF, 8'h00, 1'b1, '{SRC_DATA,  20'h00000, 8'hFF, 1'b0}},
    '{ReqWrite, 16'h0000, 8'h0A, 1'b1, '{SRC_WRITE, 20'h00000, 8'h00, 1'b0}},
    '{ReqWrite, 16'hA000, 8'h00, 1'b1, '{SRC_WRITE, 20'h00000, 8'h00, 1'b0}},
    '{ReqRead,  16'hA000, 8'h00, 1'b1, '{SRC_DATA,  20'h00000, 8'h00, 1'b0}},
    '{ReqWrite, 16'hBFFF, 8'hA5, 1'b0, NoRsp},
    '{ReqRead,  16'hBFFF, 8'h00, 1'b0, NoRsp},
    '{ReqWrite, 16'h2000, 8'h00, 1'b0, NoRsp},
    '{ReqRead,  16'h4000, 8'h00, 1'b0, NoRsp},
    '{ReqWrite, 16'h3FFF, 8'hFF, 1'b0, NoRsp},
    '{ReqWrite, 16'h4000, 8'hFF, 1'b0, NoRsp},
    '{ReqRead,  16'h7FFF, 8'h00, 1'b0, NoRsp},
    '{ReqWrite, 16'h6000, 8'hFF, 1'b0, NoRsp},
    '{ReqRead,  16'h0000, 8'h00, 1'b0, NoRsp},
    '{ReqWrite, 16'h2000, 8'h10, 1'b0, NoRsp},
    '{ReqRead,  16'h5555, 8'h00, 1'b0, NoRsp},
    '{ReqWrite, 16'h1FFF, 8'hF0, 1'b0, NoRsp},
    '{ReqWrite, 16'hE000, 8'h55, 1'b0, NoRsp},
    '{ReqRead,  16'hC000, 8'h00, 1'b0, NoRsp},
    '{ReqWrite, 16'h7FFF, 8'h00, 1'b0, NoRsp},
    '{ReqWrite, 16'h0000, 8'hFA, 1'b0, NoRsp}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_e                 cfg_index_i;
  logic [BankMaskW-1:0] cfg_data_i;

  mbcmap_req_if req_ch ();
  mbcmap_rsp_if rsp_ch ();

  multicart_rom_ram_bank_mapper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // predictor copy of the mapper state and configuration
  logic [5:0] bank_mask_q;
  logic       ram_present_q;
  logic [4:0] bank_low_q;
  logic [1:0] bank_high_q;
  logic       mode_q;
  logic       ram_en_q;
  logic [7:0] ext_ram [RamBytes];

  access_rsp_t pending_rsps [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_on;
  logic        cur_pinned;
  access_rsp_t cur_want;
  int          quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void reset_bank_state();
    bank_mask_q   = 6'd63;
    ram_present_q = 1'b1;
    bank_low_q    = 5'd1;
    bank_high_q   = 2'd0;
    mode_q        = 1'b0;
    ram_en_q      = 1'b0;
    foreach (ext_ram[i]) ext_ram[i] = OpenBus;
  endfunction

  // work out the result of one access and update the bank state
  function automatic access_rsp_t predict_access(logic wr, logic [15:0] addr,
                                                 logic [7:0] data);
    access_rsp_t r;
    win_e        win;
    logic [5:0]  bank;
    logic        was_on;
    r   = '{SRC_DATA, 20'h00000, 8'h00, 1'b0};
    win = win_e'(addr[15:13]);
    if (wr == ReqWrite) begin
      r.src = SRC_WRITE;
      case (win)
        WIN_ENABLE: begin
          if (ram_present_q) begin
            was_on   = ram_en_q;
            ram_en_q = (data[3:0] == EnableCode);
            r.ev     = was_on && !ram_en_q;
          end
        end
        WIN_BANK_LOW:  bank_low_q  = data[4:0];
        WIN_BANK_HIGH: bank_high_q = data[1:0];
        WIN_MODE:      mode_q      = data[0];
        WIN_EXT_RAM: begin
          if (ram_en_q && ram_present_q) ext_ram[addr[12:0]] = data;
        end
        default: ;
      endcase
    end else begin
      case (win)
        WIN_ENABLE, WIN_BANK_LOW: begin
          r.src = SRC_ROM;
          bank  = {bank_high_q, 4'h0} & bank_mask_q;
          r.rom_addr = mode_q ? {bank, addr[13:0]} : {4'h0, addr};
        end
        WIN_BANK_HIGH, WIN_MODE: begin
          r.src = SRC_ROM;
          // a low register of zero selects bank one above
          bank = {bank_high_q, bank_low_q[3:0]};
          if (bank_low_q == 5'd0) bank = bank + 6'd1;
          bank = bank & bank_mask_q;
          r.rom_addr = {bank, addr[13:0]};
        end
        WIN_EXT_RAM: r.rbyte = (ram_en_q && ram_present_q) ? ext_ram[addr[12:0]] : OpenBus;
        default:     r.rbyte = OpenBus;
      endcase
    end
    return r;
  endfunction

  // random access, weighted toward control sequences and ram traffic
  function automatic stim_row_t random_access();
    stim_row_t   row;
    int          kind;
    logic [12:0] ram_off;
    kind    = $urandom_range(0, 99);
    ram_off = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                          : 13'($urandom_range(0, 31));
    row        = '{ReqRead, 16'h0000, 8'($urandom), 1'b0, NoRsp};
    if (kind < 30) begin
      row.addr = 16'($urandom_range(0, 16'h7FFF));
    end else if (kind < 44) begin
      row.addr = RamBase | {3'b000, ram_off};
    end else if (kind < 58) begin
      row.wr   = ReqWrite;
      row.addr = RamBase | {3'b000, ram_off};
    end else if (kind < 68) begin
      row.wr   = ReqWrite;
      row.addr = 16'($urandom_range(0, 16'h1FFF));
      if ($urandom_range(0, 1) == 1) row.data = {4'($urandom), EnableCode};
    end else if (kind < 76) begin
      row.wr   = ReqWrite;
      row.addr = 16'h2000 | 16'($urandom_range(0, 16'h1FFF));
    end else if (kind < 83) begin
      row.wr   = ReqWrite;
      row.addr = 16'h4000 | 16'($urandom_range(0, 16'h1FFF));
    end else if (kind < 88) begin
      row.wr   = ReqWrite;
      row.addr = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
    end else begin
      row.wr   = 1'($urandom);
      row.addr = 16'($urandom);
    end
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100) $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // offer one request, with an optional idle stretch before it
  task automatic send_req(stim_row_t row);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= row.wr;
    req_ch.bus_address <= row.addr;
    req_ch.write_byte  <= row.data;
    cur_pinned         <= row.pinned;
    cur_want           <= row.want;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // stop sending and wait until every result is back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write both registers back to back while nothing is in flight
  task automatic apply_config(logic [5:0] mask, logic present);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROM_BANK_MASK;
    cfg_data_i  <= mask;
    @(posedge clk_i);
    cfg_index_i <= CFG_RAM_PRESENT;
    cfg_data_i  <= {5'b00000, present};
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    bank_mask_q   = mask;
    ram_present_q = present;
  endtask

  // result side: random or held-off ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !hold_on && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin : monitor
    access_rsp_t guess;
    access_rsp_t want;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      guess = predict_access(req_ch.req_type, req_ch.bus_address, req_ch.write_byte);
      pending_rsps.push_back(cur_pinned ? cur_want : guess);
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("result with none pending", 32'(rsp_ch.read_source), 32'h0);
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_ch.read_source !== want.src)
          report_mismatch("read_source", 32'(rsp_ch.read_source), 32'(want.src));
        if (rsp_ch.rom_address !== want.rom_addr)
          report_mismatch("rom_address", 32'(rsp_ch.rom_address), 32'(want.rom_addr));
        if (rsp_ch.read_byte !== want.rbyte)
          report_mismatch("read_byte", 32'(rsp_ch.read_byte), 32'(want.rbyte));
        if (rsp_ch.ram_disabled_event !== want.ev)
          report_mismatch("ram_disabled_event", 32'(rsp_ch.ram_disabled_event),
                          32'(want.ev));
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [5:0] phase_mask [6];
    logic       phase_ram [6];
    phase_mask = '{6'd63, 6'd0, 6'd7, 6'd31, 6'd63, 6'd1};
    phase_ram  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_ROM_BANK_MASK;
    cfg_data_i         = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = ReqRead;
    req_ch.bus_address = '0;
    req_ch.write_byte  = '0;
    rsp_ch.ready       = 1'b0;
    hold_on            = 1'b0;
    cur_pinned         = 1'b0;
    cur_want           = NoRsp;
    quiet_cycles       = 0;
    mismatches         = 0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    reset_bank_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table from the reset state
    send_idle_pct = 6;
    recv_idle_pct = 58;
    foreach (DirectedRows[i]) send_req(DirectedRows[i]);
    wait_idle();

    // random phases across mask and ram settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0:       begin send_idle_pct = 6;  recv_idle_pct = 58; end
        1:       begin send_idle_pct = 58; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      apply_config(phase_mask[ph], phase_ram[ph]);
      for (int n = 0; n < PhaseItems; n++) send_req(random_access());
      wait_idle();
    end

    // long receiver hold-off while the sender keeps offering
    apply_config(6'd15, 1'b1);
    fork
      begin
        hold_on <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_on <= 1'b0;
      end
      for (int n = 0; n < 60; n++) send_req(random_access());
    join
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
